/* rtl/core/elpc_pkg.sv */
`timescale 1ns / 1ps

package elpc_pkg;

    localparam int unsigned TICK_W     = 16;
    localparam int unsigned DIST_W     = 11;
    localparam int unsigned WHOLE_W    = 7;
    localparam int unsigned FRAC_W     = 10;
    localparam int unsigned RANGE_W    = 8;
    localparam int unsigned LEVEL_W    = 7;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // ticks*17 and fill share one working register
    localparam int unsigned X_W         = 21;
    localparam int unsigned RECIP_W     = 12;
    localparam int unsigned RECIP_SHIFT = 21;
    localparam int unsigned PROD_W      = X_W + RECIP_W;
    localparam int unsigned FILL_W      = 17;

    // long division: dist*100000 over (range - 10), one bit per cycle
    localparam int unsigned DIV_W     = 25;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [RECIP_W-1:0] RECIP_K      = 12'd2097;   // floor(2^21 / 1000)
    localparam logic [X_W-1:0]     THOUSAND     = 21'd1000;
    localparam logic [FILL_W-1:0]  FULL_SCALE   = 17'd100000;
    localparam logic [RANGE_W-1:0] RANGE_OFFSET = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_RANGE = 2'd0,
        CFG_PUMP_ON    = 2'd1,
        CFG_PUMP_OFF   = 2'd2,
        CFG_REPORT_EN  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0] echo_ticks;
        logic              echo_seen;
    } elpc_in_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance_cm;
        logic [WHOLE_W-1:0] level_whole;
        logic [FRAC_W-1:0]  level_thousandths;
        logic               pump_drive;
        logic               report_due;
    } elpc_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_MUL,
        ST_DIST_FIX,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_FILL,
        ST_LVL_MUL,
        ST_LVL_FIX,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RMUL,
        CMD_DIST,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_FILL,
        CMD_LEVEL,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic seen;
        logic div_skip;
        logic div_last;
        logic out_busy;
    } elpc_status_t;

endpackage

/* rtl/core/elpc_ctrl.sv */
`timescale 1ns / 1ps

module elpc_ctrl
    import elpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  elpc_status_t status,
    output logic         in_stall,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.seen)
                begin
                    state_next = ST_DIST_MUL;
                end
            end
            ST_DIST_MUL: state_next = ST_DIST_FIX;
            ST_DIST_FIX: state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = status.div_skip ? ST_LVL_MUL : ST_DIV_RUN;
            ST_DIV_RUN:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:     state_next = ST_LVL_MUL;
            ST_LVL_MUL:  state_next = ST_LVL_FIX;
            ST_LVL_FIX:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd      = CMD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd      = in_valid ? CMD_LOAD : CMD_NONE;
            end
            ST_DIST_MUL: cmd = CMD_RMUL;
            ST_DIST_FIX: cmd = CMD_DIST;
            ST_DIV_INIT: cmd = CMD_DIV_INIT;
            ST_DIV_RUN:  cmd = CMD_DIV_STEP;
            ST_FILL:     cmd = CMD_FILL;
            ST_LVL_MUL:  cmd = CMD_RMUL;
            ST_LVL_FIX:  cmd = CMD_LEVEL;
            ST_FINISH:   cmd = status.out_busy ? CMD_NONE : CMD_FINISH;
            default:     cmd = CMD_NONE;
        endcase
    end

endmodule

/* rtl/core/elpc_dp.sv */
`timescale 1ns / 1ps

module elpc_dp
    import elpc_pkg::*;
#(
    parameter int unsigned REPORT_PERIOD = 125
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  elpc_in_t              in_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_stall,
    output logic                  out_valid,
    output elpc_out_t             out_word,
    output elpc_status_t          status
);

    // configuration and control state
    logic [RANGE_W-1:0]   range_reg, range_next;
    logic [LEVEL_W-1:0]   on_lvl_reg, on_lvl_next;
    logic [LEVEL_W-1:0]   off_lvl_reg, off_lvl_next;
    logic                 rep_en_reg, rep_en_next;
    logic                 pump_reg, pump_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // working registers
    logic [X_W-1:0]     x_reg, x_next;
    logic [DIST_W-1:0]  q0_reg, q0_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [RANGE_W-1:0] rem_reg, rem_next;
    logic [WHOLE_W-1:0] whole_reg, whole_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic               due_reg, due_next;
    elpc_out_t          out_word_reg, out_word_next;

    logic [PROD_W-1:0]  recip_prod;
    logic [X_W-1:0]     q0_k;
    logic [X_W-1:0]     fix_rem;
    logic               fix_hi;
    logic [DIST_W-1:0]  fix_q;
    logic [X_W-1:0]     fix_r;
    logic [RANGE_W-1:0] div_v;
    logic               div_skip;
    logic [RANGE_W:0]   div_shift;
    logic               div_ge;
    logic [RANGE_W:0]   div_diff;
    logic [CNT_W-1:0]   cnt_inc;
    logic               period_hit;
    logic               pump_new;

    // x/1000: reciprocal estimate is exact or one low
    assign recip_prod = PROD_W'(x_reg) * PROD_W'(RECIP_K);
    assign q0_k       = X_W'(q0_reg) * THOUSAND;
    assign fix_rem    = x_reg - q0_k;
    assign fix_hi     = (fix_rem >= THOUSAND);
    assign fix_q      = q0_reg + DIST_W'(fix_hi);
    assign fix_r      = fix_hi ? (fix_rem - THOUSAND) : fix_rem;

    assign div_v      = range_reg - RANGE_OFFSET;
    assign div_skip   = (range_reg <= RANGE_OFFSET) || (dist_reg >= DIST_W'(div_v));
    assign div_shift  = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge     = (div_shift >= {1'b0, div_v});
    assign div_diff   = div_shift - {1'b0, div_v};

    assign cnt_inc    = (cnt_reg == {CNT_W{1'b1}}) ? cnt_reg : (cnt_reg + 1'b1);
    assign period_hit = (cnt_inc >= CNT_W'(REPORT_PERIOD));

    always_comb
    begin
        pump_new = pump_reg;
        if (!pump_reg && (whole_reg <= on_lvl_reg))
        begin
            pump_new = 1'b1;
        end
        else if (pump_reg && (whole_reg >= off_lvl_reg))
        begin
            pump_new = 1'b0;
        end
    end

    always_comb
    begin
        range_next     = range_reg;
        on_lvl_next    = on_lvl_reg;
        off_lvl_next   = off_lvl_reg;
        rep_en_next    = rep_en_reg;
        pump_next      = pump_reg;
        cnt_next       = cnt_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        x_next         = x_reg;
        q0_next        = q0_reg;
        dist_next      = dist_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        whole_next     = whole_reg;
        frac_next      = frac_reg;
        due_next       = due_reg;
        out_word_next  = out_word_reg;

        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FULL_RANGE: range_next   = cfg_data[RANGE_W-1:0];
                CFG_PUMP_ON:    on_lvl_next  = cfg_data[LEVEL_W-1:0];
                CFG_PUMP_OFF:   off_lvl_next = cfg_data[LEVEL_W-1:0];
                CFG_REPORT_EN:  rep_en_next  = cfg_data[0];
                default:        range_next   = range_reg;
            endcase
        end

        case (cmd)
            CMD_LOAD:
            begin
                x_next   = {1'b0, in_word.echo_ticks, 4'b0000}
                           + X_W'(in_word.echo_ticks);
                due_next = 1'b0;
                cnt_next = cnt_inc;
                if (in_word.echo_seen && period_hit)
                begin
                    cnt_next = '0;
                    due_next = rep_en_reg;
                end
            end
            CMD_RMUL:
            begin
                q0_next = recip_prod[RECIP_SHIFT +: DIST_W];
            end
            CMD_DIST:
            begin
                dist_next = fix_q;
            end
            CMD_DIV_INIT:
            begin
                quo_next     = DIV_W'(dist_reg[RANGE_W-1:0]) * DIV_W'(FULL_SCALE);
                rem_next     = '0;
                div_cnt_next = '0;
                if (div_skip)
                begin
                    x_next = '0;
                end
            end
            CMD_DIV_STEP:
            begin
                quo_next     = {quo_reg[DIV_W-2:0], div_ge};
                rem_next     = div_ge ? div_diff[RANGE_W-1:0] : div_shift[RANGE_W-1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            CMD_FILL:
            begin
                x_next = X_W'(FULL_SCALE) - quo_reg[X_W-1:0];
            end
            CMD_LEVEL:
            begin
                whole_next = fix_q[WHOLE_W-1:0];
                frac_next  = fix_r[FRAC_W-1:0];
            end
            CMD_FINISH:
            begin
                pump_next                       = pump_new;
                out_valid_next                  = 1'b1;
                out_word_next.distance_cm       = dist_reg;
                out_word_next.level_whole       = whole_reg;
                out_word_next.level_thousandths = frac_reg;
                out_word_next.pump_drive        = pump_new;
                out_word_next.report_due        = due_reg;
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg     <= 8'd100;
            on_lvl_reg    <= 7'd20;
            off_lvl_reg   <= 7'd90;
            rep_en_reg    <= 1'b1;
            pump_reg      <= 1'b0;
            cnt_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            range_reg     <= range_next;
            on_lvl_reg    <= on_lvl_next;
            off_lvl_reg   <= off_lvl_next;
            rep_en_reg    <= rep_en_next;
            pump_reg      <= pump_next;
            cnt_reg       <= cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        q0_reg       <= q0_next;
        dist_reg     <= dist_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        whole_reg    <= whole_next;
        frac_reg     <= frac_next;
        due_reg      <= due_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_word        = out_word_reg;
    assign status.seen     = in_word.echo_seen;
    assign status.div_skip = div_skip;
    assign status.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_W - 1));
    assign status.out_busy = out_valid_reg && out_stall;

endmodule

/* rtl/core/echo_level_pump_controller.sv */
`timescale 1ns / 1ps

// channel | direction | handshake            | word
// in      | input     | in_valid / in_stall   | in_word  (echo_ticks, echo_seen)
// out     | output    | out_valid / out_stall | out_word (distance, level, pump, report)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A word without an echo is handled in the idle state. A word with an echo runs the
// 25-step shift-subtract divider, unless the divider is skipped (surface beyond
// range, or range at or below the offset).
// Two reciprocal multiply/fix passes set the rest. The finished word waits in the
// output register; a new input word is taken while it waits.
// Reset is asynchronous; control and configuration registers return to their reset values, pump off.

module echo_level_pump_controller
    import elpc_pkg::*;
#(
    parameter int unsigned REPORT_PERIOD = 125
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  elpc_in_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output elpc_out_t             out_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t         cmd;
    elpc_status_t status;

    elpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    elpc_dp #(
        .REPORT_PERIOD (REPORT_PERIOD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (out_word),
        .status    (status)
    );

endmodule

/* rtl/core/elpc_checker.sv */
`timescale 1ns / 1ps

module elpc_checker
    import elpc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input elpc_in_t  in_word,
    input logic      out_valid,
    input logic      out_stall,
    input elpc_out_t out_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    a_echo_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.echo_seen |=> in_stall)
        else $error("echo word did not start processing");

    a_whole_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.level_whole <= 7'd100)
        else $error("level above full scale");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.level_thousandths <= 10'd999)
        else $error("thousandths out of range");

    a_full_exact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.level_whole == 7'd100 |-> out_word.level_thousandths == 10'd0)
        else $error("full level with nonzero fraction");

endmodule

bind echo_level_pump_controller elpc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
